// ===== rtl/ism_pkg.sv =====
// ----------------------------------------------------------------------------
// ism_pkg
// shared types and constants for the ising metropolis spin update block
// ----------------------------------------------------------------------------
package ism_pkg;

  // fixed field widths of the item and config interfaces
  localparam int COORD_W    = 6;
  localparam int COORD_SPAN = 1 << COORD_W;
  localparam int DRAW_W     = 16;
  localparam int CFG_W      = 16;
  localparam int BOND_W     = 4;
  localparam int DE_W       = 5;
  localparam int ENERGY_W   = 15;
  localparam int MAG_W      = 14;

  // operation codes, code 3 behaves as a query
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLIP  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // config register indexes
  localparam logic REG_PROB_FOUR  = 1'b0;
  localparam logic REG_PROB_EIGHT = 1'b1;

  // energy changes that need a random draw
  localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
  localparam logic signed [DE_W-1:0] DE_EIGHT = 5'sd8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_EXEC
  } state_t;

  // evaluation result of one site
  typedef struct packed {
    logic                     accepted;
    logic                     flip;
    logic                     new_spin;
    logic signed [BOND_W-1:0] bond;
    logic signed [DE_W-1:0]   de;
  } eval_t;

endpackage

// ===== rtl/ising_metropolis_spin_update.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// periodic 2d ising lattice with metropolis single-spin updates
// ----------------------------------------------------------------------------
// The lattice is kept as SIDE rows of SIDE spins in two row-wide synchronous
// rams holding the same data: one reads the rows above and below the site,
// the other reads the site's own row. In the cycle an item is accepted the
// three row reads are issued; in the next cycle the rows come back and the
// bond energy and acceptance are evaluated, and once the result register is
// free the changed row is written back to both rams. That read/write-back
// pair over the row rams sets the rate; the next item is only taken after
// the write, so no access to the same row can overlap. If the result register
// still holds an untaken item, the evaluation cycle waits. After reset the
// block writes all-up rows into every row before it accepts its first item;
// config writes are taken during that pass. Energy and magnetization totals
// are kept at their output widths and reported with every result.
module ising_metropolis_spin_update import ism_pkg::*; #(
  parameter int SIDE      = 64,
  parameter int PROB_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row[5:0], col[11:6], spin_value[12], random_draw[28:13]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // accepted[0], bond_energy[4:1], delta_energy[9:5],
                                  // site_spin[10], total_energy[25:11],
                                  // total_magnetization[39:26]
  // config writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IW = $clog2(SIDE);
  localparam int E_RST = -2 * SIDE * SIDE;
  localparam int M_RST = SIDE * SIDE;

  typedef logic [COORD_SPAN-1:0][IW-1:0] wrap_tab_t;

  // coordinate reduction modulo SIDE, built by a wrapping counter
  function automatic wrap_tab_t build_wrap();
    wrap_tab_t t;
    int        k;
    k = 0;
    for (int i = 0; i < COORD_SPAN; i++) begin
      t[i] = IW'(k);
      k    = (k == SIDE - 1) ? 0 : k + 1;
    end
    return t;
  endfunction

  localparam wrap_tab_t WRAP = build_wrap();

  // input fields
  logic [COORD_W-1:0] in_row;
  logic [COORD_W-1:0] in_col;
  logic               in_spin;
  logic [DRAW_W-1:0]  in_draw;
  op_t                in_op;

  assign in_row  = in_tdata[5:0];
  assign in_col  = in_tdata[11:6];
  assign in_spin = in_tdata[12];
  assign in_draw = in_tdata[28:13];
  assign in_op   = op_t'(in_tuser);

  // state and control
  state_t state_r, state_nxt;
  logic   clearing;
  logic   commit;
  logic   in_hs;
  logic [IW-1:0] clr_r, clr_nxt;

  // config registers
  logic [CFG_W-1:0] prob_four_r, prob_eight_r;

  // registered item
  op_t               op_r;
  logic [IW-1:0]     r_r, c_r, cl_r, cr_r;
  logic              spin_r;
  logic [DRAW_W-1:0] draw_r;

  // reduced coordinates and neighbours of the incoming item
  logic [IW-1:0] r_in, c_in, up_in, dn_in, cl_in, cr_in;

  // memory signals
  logic                     wr_en;
  logic [IW-1:0]            wr_addr;
  logic [SIDE-1:0]          wr_data;
  logic [1:0][IW-1:0]       nb_addr;
  logic [1:0][SIDE-1:0]     nb_rows;
  logic [0:0][IW-1:0]       ctr_addr;
  logic [0:0][SIDE-1:0]     ctr_rows;

  // evaluation
  eval_t           ev;
  logic [SIDE-1:0] new_row;

  // running totals
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [MAG_W-1:0]    magnet_r, magnet_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [39:0] out_data_r;

  always_comb begin
    r_in  = WRAP[in_row];
    c_in  = WRAP[in_col];
    up_in = (r_in == '0) ? IW'(SIDE - 1) : r_in - IW'(1);
    dn_in = (r_in == IW'(SIDE - 1)) ? '0 : r_in + IW'(1);
    cl_in = (c_in == '0) ? IW'(SIDE - 1) : c_in - IW'(1);
    cr_in = (c_in == IW'(SIDE - 1)) ? '0 : c_in + IW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == IW'(SIDE - 1)) state_nxt = ST_RUN;
      ST_RUN:   if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC:  if (!out_valid_r || out_tready) state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    clearing  = 1'b0;
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_CLEAR: clearing  = 1'b1;
      ST_RUN:   in_tready = 1'b1;
      ST_EXEC:  commit    = !out_valid_r || out_tready;
      default:  clearing  = 1'b0;
    endcase
  end

  assign in_hs   = in_tvalid && in_tready;
  assign clr_nxt = clearing ? clr_r + IW'(1) : clr_r;

  // row reads issued on accept, write back only when the site changes or while clearing
  assign nb_addr     = {dn_in, up_in};
  assign ctr_addr[0] = r_in;
  assign wr_en       = clearing || (commit && ev.flip);
  assign wr_addr     = clearing ? clr_r : r_r;
  assign wr_data     = clearing ? '1 : new_row;

  ism_ram #(
    .WIDTH    (SIDE),
    .DEPTH    (SIDE),
    .RD_PORTS (2)
  ) u_nb_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_hs),
    .rd_addr (nb_addr),
    .rd_data (nb_rows)
  );

  ism_ram #(
    .WIDTH    (SIDE),
    .DEPTH    (SIDE),
    .RD_PORTS (1)
  ) u_ctr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_hs),
    .rd_addr (ctr_addr),
    .rd_data (ctr_rows)
  );

  ism_site_eval #(
    .SIDE      (SIDE),
    .PROB_BITS (PROB_BITS)
  ) u_eval (
    .up_row     (nb_rows[0]),
    .dn_row     (nb_rows[1]),
    .ctr_row    (ctr_rows[0]),
    .col        (c_r),
    .col_lf     (cl_r),
    .col_rt     (cr_r),
    .op         (op_r),
    .spin_value (spin_r),
    .draw       (draw_r),
    .prob_four  (prob_four_r),
    .prob_eight (prob_eight_r),
    .res        (ev),
    .new_row    (new_row)
  );

  // totals move only when the site spin changes
  always_comb begin
    energy_nxt = energy_r;
    magnet_nxt = magnet_r;
    if (commit && ev.flip) begin
      energy_nxt = energy_r + {{(ENERGY_W - DE_W){ev.de[DE_W-1]}}, ev.de};
      magnet_nxt = ev.new_spin ? magnet_r + MAG_W'(2) : magnet_r - MAG_W'(2);
    end
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      energy_r     <= E_RST[ENERGY_W-1:0];
      magnet_r     <= M_RST[MAG_W-1:0];
      prob_four_r  <= '0;
      prob_eight_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      energy_r    <= energy_nxt;
      magnet_r    <= magnet_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PROB_FOUR:  prob_four_r  <= cfg_wdata;
          REG_PROB_EIGHT: prob_eight_r <= cfg_wdata;
          default:        prob_four_r  <= prob_four_r;
        endcase
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_hs) begin
      op_r   <= in_op;
      r_r    <= r_in;
      c_r    <= c_in;
      cl_r   <= cl_in;
      cr_r   <= cr_in;
      spin_r <= in_spin;
      draw_r <= in_draw;
    end
    if (commit) begin
      out_data_r <= {magnet_nxt, energy_nxt, ev.new_spin, ev.de, ev.bond, ev.accepted};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted item is always evaluated in the following cycle
  a_hs_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> (state_r == ST_EXEC))
    else $error("accepted item did not reach evaluation");

  // never overwrite a result that has not been taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_tready))
    else $error("result register overrun");

  // a changed spin moves the magnetization by exactly two
  a_mag_step: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && ev.flip) |=>
      ((magnet_r - $past(magnet_r)) == MAG_W'(2) ||
       ($past(magnet_r) - magnet_r) == MAG_W'(2)))
    else $error("magnetization step is not two");

  // a write leaves the site at the written spin
  a_write_spin: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == OP_WRITE) |-> (ev.new_spin == spin_r && !ev.accepted))
    else $error("write did not set the spin");

endmodule

// ===== rtl/ism_ram.sv =====
// ----------------------------------------------------------------------------
// ism_ram
// generic synchronous ram, one write port, registered read ports
// ----------------------------------------------------------------------------
module ism_ram import ism_pkg::*; #(
  parameter int WIDTH    = 64,
  parameter int DEPTH    = 64,
  parameter int RD_PORTS = 1
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [$clog2(DEPTH)-1:0]              wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [RD_PORTS-1:0][$clog2(DEPTH)-1:0] rd_addr,
  output logic [RD_PORTS-1:0][WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // all read ports share one registered block
  always_ff @(posedge clk) begin
    if (rd_en) begin
      for (int p = 0; p < RD_PORTS; p++) begin
        rd_data[p] <= mem[rd_addr[p]];
      end
    end
  end

endmodule

// ===== rtl/ism_site_eval.sv =====
// ----------------------------------------------------------------------------
// ism_site_eval
// bond energy, metropolis acceptance and updated row for one site
// ----------------------------------------------------------------------------
module ism_site_eval import ism_pkg::*; #(
  parameter int SIDE      = 64,
  parameter int PROB_BITS = 16
) (
  input  logic [SIDE-1:0]          up_row,
  input  logic [SIDE-1:0]          dn_row,
  input  logic [SIDE-1:0]          ctr_row,
  input  logic [$clog2(SIDE)-1:0]  col,
  input  logic [$clog2(SIDE)-1:0]  col_lf,
  input  logic [$clog2(SIDE)-1:0]  col_rt,
  input  op_t                      op,
  input  logic                     spin_value,
  input  logic [DRAW_W-1:0]        draw,
  input  logic [CFG_W-1:0]         prob_four,
  input  logic [CFG_W-1:0]         prob_eight,
  output eval_t                    res,
  output logic [SIDE-1:0]          new_row
);

  localparam int PW = (PROB_BITS < DRAW_W) ? PROB_BITS : DRAW_W;

  logic                   s;
  logic [2:0]             n_up;
  logic signed [DE_W-1:0] nsum;
  logic signed [DE_W-1:0] bond5;
  logic signed [DE_W-1:0] de;
  logic                   acc;
  logic                   flip;

  always_comb begin
    s     = ctr_row[col];
    n_up  = 3'(up_row[col]) + 3'(dn_row[col]) + 3'(ctr_row[col_lf]) + 3'(ctr_row[col_rt]);
    // neighbour sum is 2*n_up - 4
    nsum  = $signed({1'b0, n_up, 1'b0}) - 5'sd4;
    bond5 = s ? -nsum : nsum;
    de    = -(bond5 <<< 1);

    if (de <= 0) begin
      acc = 1'b1;
    end else if (de == DE_FOUR) begin
      acc = draw[PW-1:0] < prob_four[PW-1:0];
    end else if (de == DE_EIGHT) begin
      acc = draw[PW-1:0] < prob_eight[PW-1:0];
    end else begin
      acc = 1'b0;
    end

    case (op)
      OP_WRITE: flip = (s != spin_value);
      OP_FLIP:  flip = acc;
      default:  flip = 1'b0;
    endcase

    res.accepted = (op == OP_FLIP) && acc;
    res.flip     = flip;
    res.new_spin = s ^ flip;
    res.bond     = bond5[BOND_W-1:0];
    res.de       = de;

    new_row      = ctr_row;
    new_row[col] = s ^ flip;
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the ising metropolis spin update block against a lattice predictor
// ----------------------------------------------------------------------------
// The predictor keeps its own 64x64 spin lattice, running energy and
// magnetization and the two acceptance probabilities. Every input item taken
// by the block is applied to it, and the expected result is queued. Each
// result item is checked field by field against the oldest expectation.
// Stimulus starts with a directed walk through the acceptance rule, writes,
// queries and the spare opcode. Random phases follow, each under a different
// probability setting and focused on a small window of sites.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ism_pkg::*;

  localparam int         CLK_PERIOD   = 10;
  localparam int         SIDE         = 64;
  localparam int         PHASE_ITEMS  = 250;
  localparam int         IDLE_PCT     = 8;
  localparam int         QUIET_LIMIT  = 5000;
  localparam int         SETTLE       = 20;
  // opcode 3 is not in the package, the block treats it as a query
  localparam logic [1:0] OP_SPARE     = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               spin;
    logic [DRAW_W-1:0]  draw;
  } site_req_t;

  typedef struct {
    logic                       accepted;
    logic signed [BOND_W-1:0]   bond;
    logic signed [DE_W-1:0]     de;
    logic                       spin;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [MAG_W-1:0]    magnet;
  } site_res_t;

  // dut ports, all inputs driven to known values from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // row[5:0], col[11:6], spin_value[12], random_draw[28:13]
  logic [1:0]  in_tuser   = '0;  // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // accepted[0], bond_energy[4:1], delta_energy[9:5],
                                 // site_spin[10], total_energy[25:11],
                                 // total_magnetization[39:26]
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [15:0] cfg_wdata  = '0;

  // predictor state
  logic [SIDE-1:0]  lattice [SIDE];
  int               energy_total = -2 * SIDE * SIDE;
  int               magnet_total = SIDE * SIDE;
  logic [CFG_W-1:0] prob_four    = '0;
  logic [CFG_W-1:0] prob_eight   = '0;

  // stimulus and scoreboard
  site_req_t pending_sites [$];
  site_res_t site_results  [$];
  site_req_t sent_req;
  logic      steady        = 1'b0;  // no idling on either side while set
  int        fail_count    = 0;
  int        items_checked = 0;
  int        flips_taken   = 0;
  int        settings_run  = 0;
  int        quiet_cycles  = 0;

  ising_metropolis_spin_update #(
    .SIDE      (SIDE),
    .PROB_BITS (DRAW_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int spin_sign(logic s);
    return s ? 1 : -1;
  endfunction

  // metropolis step on the predictor lattice, returns the expected result
  function automatic site_res_t apply_site_update(site_req_t req);
    logic [COORD_W-1:0] r_up, r_dn, c_lf, c_rt;
    int                 nsum, bond, de;
    logic               acc, flip;
    site_res_t          res;
    // six-bit coordinates wrap around the lattice on their own
    r_up = req.row - 1'b1;
    r_dn = req.row + 1'b1;
    c_lf = req.col - 1'b1;
    c_rt = req.col + 1'b1;
    nsum = spin_sign(lattice[r_up][req.col]) + spin_sign(lattice[r_dn][req.col]) +
           spin_sign(lattice[req.row][c_lf]) + spin_sign(lattice[req.row][c_rt]);
    bond = -spin_sign(lattice[req.row][req.col]) * nsum;
    de   = -2 * bond;
    acc  = 1'b0;
    flip = 1'b0;
    if (req.op == OP_WRITE) begin
      flip = lattice[req.row][req.col] != req.spin;
    end else if (req.op == OP_FLIP) begin
      // downhill and level moves always go, uphill needs the draw below the probability
      if (de <= 0) begin
        acc = 1'b1;
      end else if (de == 4) begin
        acc = req.draw < prob_four;
      end else if (de == 8) begin
        acc = req.draw < prob_eight;
      end
      flip = acc;
    end
    if (flip) begin
      lattice[req.row][req.col] = ~lattice[req.row][req.col];
      energy_total += de;
      magnet_total += lattice[req.row][req.col] ? 2 : -2;
    end
    res.accepted = acc;
    res.bond     = bond[BOND_W-1:0];
    res.de       = de[DE_W-1:0];
    res.spin     = lattice[req.row][req.col];
    res.energy   = energy_total[ENERGY_W-1:0];
    res.magnet   = magnet_total[MAG_W-1:0];
    return res;
  endfunction

  function automatic site_req_t site_req(logic [1:0] op, int row, int col, logic spin,
                                         logic [DRAW_W-1:0] draw);
    site_req_t req;
    req.op   = op;
    req.row  = row[COORD_W-1:0];
    req.col  = col[COORD_W-1:0];
    req.spin = spin;
    req.draw = draw;
    return req;
  endfunction

  // half flips, mostly inside a 5x5 window so the spins there get mixed up,
  // some items land anywhere on the lattice
  function automatic site_req_t random_site_req(int base_row, int base_col);
    site_req_t req;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      req.op = OP_FLIP;
    end else if (pick < 75) begin
      req.op = OP_WRITE;
    end else if (pick < 95) begin
      req.op = OP_QUERY;
    end else begin
      req.op = OP_SPARE;
    end
    if ($urandom_range(3) != 0) begin
      pick    = base_row + $urandom_range(4);
      req.row = pick[COORD_W-1:0];
      pick    = base_col + $urandom_range(4);
      req.col = pick[COORD_W-1:0];
    end else begin
      req.row = COORD_W'($urandom_range(SIDE - 1));
      req.col = COORD_W'($urandom_range(SIDE - 1));
    end
    req.spin = 1'($urandom_range(1));
    req.draw = DRAW_W'($urandom_range(16'hFFFF));
    return req;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // both registers, written only while nothing is in flight
  task automatic write_probs(logic [CFG_W-1:0] four, logic [CFG_W-1:0] eight);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PROB_FOUR;
    cfg_wdata <= four;
    @(posedge clk);
    cfg_index <= REG_PROB_EIGHT;
    cfg_wdata <= eight;
    @(posedge clk);
    cfg_we    <= 1'b0;
    prob_four  = four;
    prob_eight = eight;
    settings_run++;
  endtask

  // sender hold-off: wait until every queued item is out and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_sites.size() != 0 || in_tvalid || site_results.size() != 0);
  endtask

  // input driver, predicts on every accepted item
  always @(posedge clk) begin
    site_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        site_results.push_back(apply_site_update(sent_req));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_sites.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          req = pending_sites.pop_front();
          sent_req  <= req;
          in_tdata  <= {3'b000, req.draw, req.spin, req.col, req.row};
          in_tuser  <= req.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    site_res_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.accepted = out_tdata[0];
        got.bond     = out_tdata[4:1];
        got.de       = out_tdata[9:5];
        got.spin     = out_tdata[10];
        got.energy   = out_tdata[25:11];
        got.magnet   = out_tdata[39:26];
        if (site_results.size() == 0) begin
          $error("result item arrived with nothing expected");
          fail_count++;
        end else begin
          want = site_results.pop_front();
          compare_field("accepted", longint'(want.accepted), longint'(got.accepted));
          compare_field("bond_energy", longint'(want.bond), longint'(got.bond));
          compare_field("delta_energy", longint'(want.de), longint'(got.de));
          compare_field("site_spin", longint'(want.spin), longint'(got.spin));
          compare_field("total_energy", longint'(want.energy), longint'(got.energy));
          compare_field("total_magnetization", longint'(want.magnet),
                        longint'(got.magnet));
          items_checked++;
          if (want.accepted) begin
            flips_taken++;
          end
        end
      end
      out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] four_set  [6];
    logic [CFG_W-1:0] eight_set [6];
    int               base_row, base_col;
    foreach (lattice[i]) begin
      lattice[i] = '1;
    end
    // cold, hot, random, frozen, and two lopsided settings
    four_set  = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h4000, 16'h0001};
    eight_set = '{16'h2000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0400, 16'hFFFE};
    four_set[2]  = CFG_W'($urandom_range(16'hFFFF));
    eight_set[2] = CFG_W'($urandom_range(16'hFFFF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // probabilities of zero: uphill flips must never go
    write_probs(16'h0000, 16'h0000);
    pending_sites.push_back(site_req(OP_QUERY, 0, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_QUERY, 63, 63, 1'b1, 16'hFFFF));
    pending_sites.push_back(site_req(OP_SPARE, 63, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_FLIP, 0, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_WRITE, 0, 0, 1'b1, 16'h0000));  // same spin
    pending_sites.push_back(site_req(OP_WRITE, 0, 0, 1'b0, 16'hFFFF));  // spin changes
    pending_sites.push_back(site_req(OP_WRITE, 0, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_QUERY, 0, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_FLIP, 0, 0, 1'b0, 16'hFFFF));   // downhill by 8
    pending_sites.push_back(site_req(OP_WRITE, 63, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_FLIP, 0, 0, 1'b0, 16'h0000));   // uphill by 4
    pending_sites.push_back(site_req(OP_WRITE, 0, 1, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_WRITE, 1, 0, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_FLIP, 0, 0, 1'b1, 16'hFFFF));   // downhill by 4
    wait_drained();

    // probabilities at full scale: a draw of all ones still fails
    write_probs(16'hFFFF, 16'hFFFF);
    pending_sites.push_back(site_req(OP_FLIP, 32, 32, 1'b0, 16'hFFFF));
    pending_sites.push_back(site_req(OP_FLIP, 32, 32, 1'b0, 16'hFFFE));
    pending_sites.push_back(site_req(OP_FLIP, 32, 33, 1'b0, 16'hFFFF));
    pending_sites.push_back(site_req(OP_FLIP, 32, 33, 1'b0, 16'hFFFE));
    pending_sites.push_back(site_req(OP_WRITE, 39, 40, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_WRITE, 41, 40, 1'b0, 16'h0000));
    pending_sites.push_back(site_req(OP_FLIP, 40, 40, 1'b0, 16'hFFFF)); // no energy change
    pending_sites.push_back(site_req(OP_FLIP, 40, 40, 1'b1, 16'hFFFF));
    pending_sites.push_back(site_req(OP_QUERY, 31, 31, 1'b1, 16'hFFFF));
    pending_sites.push_back(site_req(OP_SPARE, 32, 32, 1'b1, 16'h5555));
    wait_drained();

    // random phases, one probability setting each, the second without idling
    for (int phase = 0; phase < 6; phase++) begin
      write_probs(four_set[phase], eight_set[phase]);
      steady   = (phase == 1);
      base_row = (phase == 0) ? 62 : $urandom_range(SIDE - 1);
      base_col = (phase == 0) ? 62 : $urandom_range(SIDE - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pending_sites.push_back(random_site_req(base_row, base_col));
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (SETTLE) @(posedge clk);
    if (site_results.size() != 0) begin
      $error("%0d result items never arrived", site_results.size());
      fail_count++;
    end
    $display("checked %0d result items over %0d probability settings",
             items_checked, settings_run);
    $display("%0d metropolis flips accepted, energy ended at %0d, magnetization at %0d",
             flips_taken, energy_total, magnet_total);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== ising_metropolis_spin_update.f =====
rtl/ism_pkg.sv
rtl/ism_ram.sv
rtl/ism_site_eval.sv
rtl/ising_metropolis_spin_update.sv
test/testbench.sv
